@@ hw/rtl/ddt_pkg.sv @@
// ----------------------------------------------------------------------------
// ddt_pkg
// Shared types and constants of the dataflow depth tracker.
// ----------------------------------------------------------------------------
package ddt_pkg;

    localparam int NUM_REGS_DEF    = 32;
    localparam int NUM_OPCODES_DEF = 16;
    localparam int MAX_INSTS_DEF   = 65536;

    localparam int REG_W    = 5;
    localparam int OP_W     = 4;
    localparam int INST_W   = 16;
    localparam int DEP_W    = 17;
    localparam int DEPTH_W  = 24;
    localparam int LAT_W    = 8;
    localparam int WORD_W   = 64;
    localparam int CFG_IDX_W = 8;

    localparam logic [DEPTH_W-1:0] FINISH_MAX = {DEPTH_W{1'b1}};
    localparam logic [DEP_W-1:0]   DEP_NONE   = {DEP_W{1'b1}};
    localparam logic [WORD_W-1:0]  LAT_RESET  = 64'h0101_0101_0101_0101;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LAT_LO = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LAT_HI = 8'd1;

    typedef struct packed {
        logic              start_program;
        logic [OP_W-1:0]   opcode;
        logic [REG_W-1:0]  dst_reg;
        logic [REG_W-1:0]  src1_reg;
        logic [REG_W-1:0]  src2_reg;
    } instr_t;

    typedef struct packed {
        logic [INST_W-1:0]  inst_index;
        logic [DEP_W-1:0]   dep1_index;
        logic [DEP_W-1:0]   dep2_index;
        logic [DEPTH_W-1:0] inst_depth;
        logic [DEPTH_W-1:0] prog_depth;
        logic               saturated;
    } result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [WORD_W-1:0]    data;
    } cfg_t;

    // one writer table entry
    typedef struct packed {
        logic [INST_W-1:0]  index;
        logic [DEPTH_W-1:0] finish;
    } entry_t;

endpackage

@@ hw/rtl/ddt_chan_if.sv @@
// ----------------------------------------------------------------------------
// ddt_chan_if
// Valid/ready channel carrying one payload word per transfer.
// ----------------------------------------------------------------------------
interface ddt_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/dataflow_depth_tracker_core.sv @@
// ----------------------------------------------------------------------------
// dataflow_depth_tracker_core
// Tracks last writer per register and reports dependency depth per instruction.
// ----------------------------------------------------------------------------
// Order: the table reads and the instruction are registered on the transfer,
//   then the result is computed into the output register as stage 1 advances.
// Throughput: one instruction per cycle unless the result stalls; the writer
//   table has two read ports, one write port, and a one-entry write-back bypass.
// Reset: rst_n clears pipeline valids, writer valid bits, counters; latencies = 1.
module dataflow_depth_tracker_core #(
    parameter int NUM_REGS    = ddt_pkg::NUM_REGS_DEF,
    parameter int NUM_OPCODES = ddt_pkg::NUM_OPCODES_DEF,
    parameter int MAX_INSTS   = ddt_pkg::MAX_INSTS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ddt_chan_if.sink   instr,
    ddt_chan_if.source result,
    ddt_chan_if.sink   cfg
);

    localparam int ADDR_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int CNT_W  = $clog2(MAX_INSTS);

    // ---------------- configuration ----------------
    logic [ddt_pkg::WORD_W-1:0] lat_lo_reg, lat_hi_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_lo_reg <= ddt_pkg::LAT_RESET;
            lat_hi_reg <= ddt_pkg::LAT_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.data.index == ddt_pkg::REG_LAT_LO)
                lat_lo_reg <= cfg.data.data;
            else if (cfg.data.index == ddt_pkg::REG_LAT_HI)
                lat_hi_reg <= cfg.data.data;
        end
    end

    // ---------------- pipeline control ----------------
    logic           s1_vld_reg;
    ddt_pkg::instr_t s1_reg;
    logic           out_vld_reg;
    ddt_pkg::result_t out_reg;
    logic           s1_adv;
    logic           in_xfer;

    assign s1_adv      = s1_vld_reg && (!out_vld_reg || result.ready);
    assign instr.ready = !s1_vld_reg || s1_adv;
    assign in_xfer     = instr.valid && instr.ready;

    // ---------------- writer table ----------------
    ddt_pkg::entry_t mem [NUM_REGS];
    ddt_pkg::entry_t rd1_reg, rd2_reg;
    logic            wr_en;
    logic [ADDR_W-1:0] wr_addr;
    ddt_pkg::entry_t wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (in_xfer)
        begin
            rd1_reg <= mem[ADDR_W'(instr.data.src1_reg)];
            rd2_reg <= mem[ADDR_W'(instr.data.src2_reg)];
        end
    end

    // valid bits and bypass of the most recent write
    logic [NUM_REGS-1:0] wvld_reg, wvld_next;
    logic                fwd_vld_reg;
    logic [ADDR_W-1:0]   fwd_addr_reg;
    ddt_pkg::entry_t     fwd_data_reg;

    // ---------------- stage 1: lookup and compute ----------------
    logic [ADDR_W-1:0] a1, a2;
    logic              in1, in2, hit1, hit2, dst_ok;
    ddt_pkg::entry_t   e1, e2;
    logic [ddt_pkg::DEPTH_W-1:0] f1, f2, depth, finish;
    logic [ddt_pkg::DEPTH_W:0]   sum;
    logic [ddt_pkg::WORD_W-1:0]  lat_word;
    logic [ddt_pkg::LAT_W-1:0]   lat;
    logic                        sat;
    logic [CNT_W-1:0]            cnt_reg, cnt_next, me;
    logic [ddt_pkg::DEPTH_W-1:0] maxf_reg, maxf_next, maxf_base;

    assign a1  = ADDR_W'(s1_reg.src1_reg);
    assign a2  = ADDR_W'(s1_reg.src2_reg);
    assign in1 = 32'(s1_reg.src1_reg) < NUM_REGS;
    assign in2 = 32'(s1_reg.src2_reg) < NUM_REGS;
    assign dst_ok = 32'(s1_reg.dst_reg) < NUM_REGS;

    always_comb
    begin
        // a start flag means no producers at all for this instruction
        hit1 = in1 && !s1_reg.start_program && wvld_reg[a1];
        hit2 = in2 && !s1_reg.start_program && wvld_reg[a2];
        e1 = (fwd_vld_reg && fwd_addr_reg == a1) ? fwd_data_reg : rd1_reg;
        e2 = (fwd_vld_reg && fwd_addr_reg == a2) ? fwd_data_reg : rd2_reg;
        f1 = hit1 ? e1.finish : '0;
        f2 = hit2 ? e2.finish : '0;
        depth = (f1 > f2) ? f1 : f2;

        lat_word = s1_reg.opcode[ddt_pkg::OP_W-1] ? lat_hi_reg : lat_lo_reg;
        lat = (32'(s1_reg.opcode) < NUM_OPCODES)
            ? lat_word[s1_reg.opcode[2:0]*ddt_pkg::LAT_W +: ddt_pkg::LAT_W] : '0;
        sum = {1'b0, depth} + (ddt_pkg::DEPTH_W+1)'(lat);
        sat = sum[ddt_pkg::DEPTH_W];
        finish = sat ? ddt_pkg::FINISH_MAX : sum[ddt_pkg::DEPTH_W-1:0];

        me        = s1_reg.start_program ? '0 : cnt_reg;
        maxf_base = s1_reg.start_program ? '0 : maxf_reg;
        maxf_next = (finish > maxf_base) ? finish : maxf_base;
        cnt_next  = (me == CNT_W'(MAX_INSTS - 1)) ? '0 : me + 1'b1;

        wr_en   = s1_adv && dst_ok;
        wr_addr = ADDR_W'(s1_reg.dst_reg);
        wr_data.index  = ddt_pkg::INST_W'(me);
        wr_data.finish = finish;

        wvld_next = s1_reg.start_program ? '0 : wvld_reg;
        if (dst_ok)
            wvld_next[wr_addr] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            wvld_reg    <= '0;
            fwd_vld_reg <= 1'b0;
            cnt_reg     <= '0;
            maxf_reg    <= '0;
        end
        else
        begin
            if (in_xfer)
                s1_vld_reg <= 1'b1;
            else if (s1_adv)
                s1_vld_reg <= 1'b0;

            if (s1_adv)
            begin
                out_vld_reg <= 1'b1;
                wvld_reg    <= wvld_next;
                cnt_reg     <= cnt_next;
                maxf_reg    <= maxf_next;
            end
            else if (result.ready)
                out_vld_reg <= 1'b0;

            if (wr_en)
                fwd_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            s1_reg <= instr.data;
        if (wr_en)
        begin
            fwd_addr_reg <= wr_addr;
            fwd_data_reg <= wr_data;
        end
        if (s1_adv)
        begin
            out_reg.inst_index <= ddt_pkg::INST_W'(me);
            out_reg.dep1_index <= hit1 ? {1'b0, e1.index} : ddt_pkg::DEP_NONE;
            out_reg.dep2_index <= hit2 ? {1'b0, e2.index} : ddt_pkg::DEP_NONE;
            out_reg.inst_depth <= depth;
            out_reg.prog_depth <= maxf_next;
            out_reg.saturated  <= sat;
        end
    end

    assign result.valid = out_vld_reg;
    assign result.data  = out_reg;

    // ---------------- assertions ----------------
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_vld_reg && !s1_adv |=> s1_vld_reg && $stable(s1_reg))
        else $error("stage 1 item lost while stalled");

    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_reg.saturated |-> out_reg.prog_depth == ddt_pkg::FINISH_MAX)
        else $error("saturated result without clipped program depth");

    a_depth_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> out_reg.inst_depth <= out_reg.prog_depth)
        else $error("instruction depth exceeds program depth");

endmodule
